// ----- rtl/qicf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qicf_pkg
// Shared types and constants of the continued fraction expander.
// ----------------------------------------------------------------------------
package qicf_pkg;

	localparam int MAX_TERMS_DEF = 64;
	localparam int DW            = 64;
	localparam int TERM_W        = 32;
	localparam int FIFO_DEPTH    = 2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
	localparam logic [1:0] STATUS_LIMIT    = 2'd2;

	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_SQUARE,
		CLS_IRR
	} cls_t;

	typedef struct packed {
		logic [15:0] s_start;
		logic [15:0] radicand;
		logic [15:0] t_start;
		logic [7:0]  root;
		cls_t        cls;
	} item_t;

endpackage

// ----- rtl/qicf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qicf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module qicf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/qicf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qicf_front
// Accepts a request, takes the 8-bit square root of the radicand and
// classifies it as zero denominator, square radicand or irrational.
// ----------------------------------------------------------------------------
module qicf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [15:0]         s_start,
	input  logic [15:0]         radicand,
	input  logic [15:0]         t_start,
	output logic                push,
	output qicf_pkg::item_t     push_item,
	input  logic                full
);

	typedef enum logic [1:0] {
		F_IDLE,
		F_SQRT,
		F_PUSH
	} fstate_t;

	fstate_t         state_q;
	qicf_pkg::item_t item_q;
	logic [15:0]     v_q;
	logic [15:0]     res_q;
	logic [15:0]     bit_q;
	logic [2:0]      cnt_q;
	logic [16:0]     trial;

	assign trial     = {1'b0, res_q} + {1'b0, bit_q};
	assign busy      = (state_q != F_IDLE);
	assign push      = (state_q == F_PUSH) && !full && (cnt_q == 3'd0);
	assign push_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						item_q.s_start  <= s_start;
						item_q.radicand <= radicand;
						item_q.t_start  <= t_start;
						item_q.root     <= '0;
						v_q   <= radicand;
						res_q <= '0;
						bit_q <= 16'h4000;
						cnt_q <= '0;
						if (t_start == 16'd0) begin
							item_q.cls <= qicf_pkg::CLS_ZERO;
							state_q    <= F_PUSH;
						end else begin
							item_q.cls <= qicf_pkg::CLS_IRR;
							state_q    <= F_SQRT;
						end
					end
				end
				F_SQRT: begin
					if ({1'b0, v_q} >= trial) begin
						v_q   <= v_q - trial[15:0];
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= (cnt_q == 3'd7) ? 3'd1 : cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (item_q.cls != qicf_pkg::CLS_ZERO) begin
						item_q.root <= res_q[7:0];
						item_q.cls  <= (v_q == 16'd0) ? qicf_pkg::CLS_SQUARE
						                              : qicf_pkg::CLS_IRR;
					end
					if (!full && cnt_q == 3'd0) begin
						state_q <= F_IDLE;
					end
					cnt_q <= '0;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/qicf_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qicf_fifo
// Short request queue between the front and the term engine.
// ----------------------------------------------------------------------------
module qicf_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  qicf_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output qicf_pkg::item_t pop_item,
	output logic            empty
);

	localparam int D  = qicf_pkg::FIFO_DEPTH;
	localparam int PW = (D > 1) ? $clog2(D) : 1;
	localparam int CW = $clog2(D + 1);

	qicf_pkg::item_t mem_q [D];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   cnt_q;

	assign full     = (cnt_q == CW'(D));
	assign empty    = (cnt_q == '0);
	assign pop_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(D - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(D - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- rtl/qicf_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qicf_engine
// Runs the continued fraction recurrence with a shared multiplier, floor
// divider and square root unit, keeps the (s, t) history, then streams terms.
// ----------------------------------------------------------------------------
module qicf_engine #(
	parameter int MAX_TERMS = qicf_pkg::MAX_TERMS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         empty,
	input  qicf_pkg::item_t              pop_item,
	output logic                         pop,
	output logic                         strobe,
	output logic [qicf_pkg::TERM_W-1:0]  term,
	output logic                         is_period_start,
	output logic                         is_last,
	output logic                         is_periodic,
	output logic [1:0]                   status
);

	localparam int W   = qicf_pkg::DW;
	localparam int TW  = qicf_pkg::TERM_W;
	localparam int AW  = $clog2(MAX_TERMS);
	localparam int NW  = $clog2(MAX_TERMS + 1);
	localparam int MST = W / 4;
	localparam int MCW = $clog2(MST);
	localparam int DCW = $clog2(W);
	localparam int SST = W / 2;
	localparam int SCW = $clog2(SST);

	typedef enum logic [4:0] {
		E_IDLE, E_QDIV, E_CHK_MUL, E_CHK_DIV, E_SC1, E_SC2, E_SC3, E_SQRT,
		E_ADIV, E_AMUL, E_SMUL, E_TDIV, E_HWAIT, E_HCMP, E_HWR, E_EMIT
	} estate_t;

	estate_t               state_q;
	logic signed [W-1:0]   s_q, t_q, d_q, root_q, at_q, op_a_q, op_b_q;
	logic [NW-1:0]         n_q, k_q;
	logic [AW-1:0]         j_q, period_q;
	logic                  found_q, per_q;
	logic [1:0]            st_q;
	logic                  mul_go_q, div_go_q, sq_go_q;

	// multiplier, four bits a cycle
	logic [W-1:0]          ma_q, mb_q, macc_q, pp;
	logic [MCW-1:0]        mcnt_q;
	logic                  mul_busy_q, mul_done_q;
	logic signed [W-1:0]   prod;

	// restoring divider on magnitudes
	logic [W-1:0]          dquo_q, ddm_q;
	logic [W:0]            drem_q, drsh;
	logic signed [W-1:0]   ddv_q;
	logic                  dnneg_q, ddneg_q;
	logic [DCW-1:0]        dcnt_q;
	logic                  div_busy_q, div_done_q;
	logic [W-1:0]          dnm, ddm, dqs, drm, drt;
	logic                  dneg, dadj;
	logic signed [W-1:0]   q_floor, r_floor;

	// integer square root
	logic [W-1:0]          sv_q, sres_q, sbit_q, strial;
	logic [SCW-1:0]        scnt_q;
	logic                  sq_busy_q, sq_done_q;

	// rams
	logic                  tr_we_q, hr_we_q;
	logic [AW-1:0]         tr_wa_q, tr_ra_q, hr_wa_q, hr_ra_q;
	logic [TW-1:0]         tr_wd_q, tr_rdata;
	logic [2*W-1:0]        hr_wd_q, hr_rdata;

	// output pipeline
	logic                  rd_v_s1, zero_s1, ps_s1, last_s1, per_s1;
	logic [1:0]            st_s1;
	logic                  rd_v_s2, zero_s2, ps_s2, last_s2, per_s2;
	logic [1:0]            st_s2;
	logic                  strobe_q, ps_q, last_q, perio_q;
	logic [TW-1:0]         term_q;
	logic [1:0]            status_q;

	// unpacked request
	logic signed [W-1:0]   it_s, it_t, it_d, it_r, sq_p;
	logic signed [W-1:0]   s_next, a_num;

	assign it_s  = {{(W-16){pop_item.s_start[15]}}, pop_item.s_start};
	assign it_t  = {{(W-16){pop_item.t_start[15]}}, pop_item.t_start};
	assign it_d  = {{(W-16){1'b0}}, pop_item.radicand};
	assign it_r  = {{(W-8){1'b0}}, pop_item.root};
	assign sq_p  = it_s + it_r;
	assign pop   = (state_q == E_IDLE) && !empty;
	assign prod  = $signed(macc_q);
	assign s_next = prod - s_q;
	assign a_num = s_q + root_q + ((t_q < 0) ? W'(1) : W'(0));

	always_comb begin
		pp = ({W{mb_q[0]}} & ma_q) + ({W{mb_q[1]}} & (ma_q << 1))
		   + ({W{mb_q[2]}} & (ma_q << 2)) + ({W{mb_q[3]}} & (ma_q << 3));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_done_q <= 1'b0;
			mcnt_q     <= '0;
		end else begin
			mul_done_q <= 1'b0;
			if (mul_go_q) begin
				ma_q       <= op_a_q;
				mb_q       <= op_b_q;
				macc_q     <= '0;
				mcnt_q     <= '0;
				mul_busy_q <= 1'b1;
			end else if (mul_busy_q) begin
				macc_q <= macc_q + pp;
				ma_q   <= ma_q << 4;
				mb_q   <= mb_q >> 4;
				mcnt_q <= mcnt_q + MCW'(1);
				if (mcnt_q == MCW'(MST - 1)) begin
					mul_busy_q <= 1'b0;
					mul_done_q <= 1'b1;
				end
			end
		end
	end

	assign dnm  = op_a_q[W-1] ? (~op_a_q + W'(1)) : op_a_q;
	assign ddm  = op_b_q[W-1] ? (~op_b_q + W'(1)) : op_b_q;
	assign drsh = {drem_q[W-1:0], dquo_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			dcnt_q     <= '0;
		end else begin
			div_done_q <= 1'b0;
			if (div_go_q) begin
				dquo_q     <= dnm;
				drem_q     <= '0;
				ddm_q      <= ddm;
				ddv_q      <= op_b_q;
				dnneg_q    <= op_a_q[W-1];
				ddneg_q    <= op_b_q[W-1];
				dcnt_q     <= '0;
				div_busy_q <= 1'b1;
			end else if (div_busy_q) begin
				if (drsh >= {1'b0, ddm_q}) begin
					drem_q <= drsh - {1'b0, ddm_q};
					dquo_q <= {dquo_q[W-2:0], 1'b1};
				end else begin
					drem_q <= drsh;
					dquo_q <= {dquo_q[W-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q + DCW'(1);
				if (dcnt_q == DCW'(W - 1)) begin
					div_busy_q <= 1'b0;
					div_done_q <= 1'b1;
				end
			end
		end
	end

	assign drm     = drem_q[W-1:0];
	assign dneg    = dnneg_q ^ ddneg_q;
	assign dadj    = dneg && (drm != '0);
	assign dqs     = dneg ? (~dquo_q + W'(1)) : dquo_q;
	assign drt     = dnneg_q ? (~drm + W'(1)) : drm;
	assign q_floor = $signed(dqs) - (dadj ? W'(1) : W'(0));
	assign r_floor = $signed(drt) + (dadj ? ddv_q : W'(0));

	assign strial = sres_q + sbit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_done_q <= 1'b0;
			scnt_q    <= '0;
		end else begin
			sq_done_q <= 1'b0;
			if (sq_go_q) begin
				sv_q      <= op_a_q;
				sres_q    <= '0;
				sbit_q    <= W'(1) << (W - 2);
				scnt_q    <= '0;
				sq_busy_q <= 1'b1;
			end else if (sq_busy_q) begin
				if (sv_q >= strial) begin
					sv_q   <= sv_q - strial;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
				scnt_q <= scnt_q + SCW'(1);
				if (scnt_q == SCW'(SST - 1)) begin
					sq_busy_q <= 1'b0;
					sq_done_q <= 1'b1;
				end
			end
		end
	end

	qicf_ram #(.WIDTH(TW), .DEPTH(MAX_TERMS)) u_term_ram (
		.clk   (clk),
		.we    (tr_we_q),
		.waddr (tr_wa_q),
		.wdata (tr_wd_q),
		.raddr (tr_ra_q),
		.rdata (tr_rdata)
	);

	qicf_ram #(.WIDTH(2 * W), .DEPTH(MAX_TERMS)) u_hist_ram (
		.clk   (clk),
		.we    (hr_we_q),
		.waddr (hr_wa_q),
		.wdata (hr_wd_q),
		.raddr (hr_ra_q),
		.rdata (hr_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= E_IDLE;
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			sq_go_q  <= 1'b0;
			tr_we_q  <= 1'b0;
			hr_we_q  <= 1'b0;
			rd_v_s1  <= 1'b0;
			n_q      <= '0;
			k_q      <= '0;
			j_q      <= '0;
			found_q  <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			sq_go_q  <= 1'b0;
			tr_we_q  <= 1'b0;
			hr_we_q  <= 1'b0;
			rd_v_s1  <= 1'b0;
			unique case (state_q)
				E_IDLE: begin
					if (!empty) begin
						s_q     <= it_s;
						t_q     <= it_t;
						d_q     <= it_d;
						root_q  <= it_r;
						n_q     <= '0;
						found_q <= 1'b0;
						unique case (pop_item.cls)
							qicf_pkg::CLS_ZERO: begin
								rd_v_s1 <= 1'b1;
								zero_s1 <= 1'b1;
								ps_s1   <= 1'b0;
								last_s1 <= 1'b1;
								per_s1  <= 1'b0;
								st_s1   <= qicf_pkg::STATUS_ZERO_DEN;
							end
							qicf_pkg::CLS_SQUARE: begin
								s_q      <= (it_t < 0) ? -sq_p : sq_p;
								t_q      <= (it_t < 0) ? -it_t : it_t;
								op_a_q   <= (it_t < 0) ? -sq_p : sq_p;
								op_b_q   <= (it_t < 0) ? -it_t : it_t;
								div_go_q <= 1'b1;
								state_q  <= E_QDIV;
							end
							default: begin
								op_a_q   <= it_s;
								op_b_q   <= it_s;
								mul_go_q <= 1'b1;
								state_q  <= E_CHK_MUL;
							end
						endcase
					end
				end
				E_QDIV: begin
					if (div_done_q) begin
						tr_we_q <= 1'b1;
						tr_wa_q <= n_q[AW-1:0];
						tr_wd_q <= q_floor[TW-1:0];
						n_q     <= n_q + NW'(1);
						if (r_floor == '0 || n_q + NW'(1) == NW'(MAX_TERMS)) begin
							per_q   <= 1'b0;
							st_q    <= qicf_pkg::STATUS_OK;
							k_q     <= '0;
							state_q <= E_EMIT;
						end else begin
							s_q      <= t_q;
							t_q      <= r_floor;
							op_a_q   <= t_q;
							op_b_q   <= r_floor;
							div_go_q <= 1'b1;
						end
					end
				end
				E_CHK_MUL: begin
					if (mul_done_q) begin
						op_a_q   <= d_q - prod;
						op_b_q   <= t_q;
						div_go_q <= 1'b1;
						state_q  <= E_CHK_DIV;
					end
				end
				E_CHK_DIV: begin
					if (div_done_q) begin
						if (r_floor != '0) begin
							at_q     <= (t_q < 0) ? -t_q : t_q;
							op_a_q   <= s_q;
							op_b_q   <= (t_q < 0) ? -t_q : t_q;
							mul_go_q <= 1'b1;
							state_q  <= E_SC1;
						end else begin
							op_a_q  <= d_q;
							sq_go_q <= 1'b1;
							state_q <= E_SQRT;
						end
					end
				end
				E_SC1: begin
					if (mul_done_q) begin
						s_q      <= prod;
						op_a_q   <= t_q;
						op_b_q   <= at_q;
						mul_go_q <= 1'b1;
						state_q  <= E_SC2;
					end
				end
				E_SC2: begin
					if (mul_done_q) begin
						t_q      <= prod;
						op_a_q   <= d_q;
						op_b_q   <= (prod < 0) ? -prod : prod;
						mul_go_q <= 1'b1;
						state_q  <= E_SC3;
					end
				end
				E_SC3: begin
					if (mul_done_q) begin
						d_q     <= prod;
						op_a_q  <= prod;
						sq_go_q <= 1'b1;
						state_q <= E_SQRT;
					end
				end
				E_SQRT: begin
					if (sq_done_q) begin
						root_q   <= $signed(sres_q);
						op_a_q   <= s_q + $signed(sres_q) + ((t_q < 0) ? W'(1) : W'(0));
						op_b_q   <= t_q;
						div_go_q <= 1'b1;
						state_q  <= E_ADIV;
					end
				end
				E_ADIV: begin
					if (div_done_q) begin
						tr_we_q  <= 1'b1;
						tr_wa_q  <= n_q[AW-1:0];
						tr_wd_q  <= q_floor[TW-1:0];
						op_a_q   <= q_floor;
						op_b_q   <= t_q;
						mul_go_q <= 1'b1;
						state_q  <= E_AMUL;
					end
				end
				E_AMUL: begin
					if (mul_done_q) begin
						s_q      <= s_next;
						op_a_q   <= s_next;
						op_b_q   <= s_next;
						mul_go_q <= 1'b1;
						state_q  <= E_SMUL;
					end
				end
				E_SMUL: begin
					if (mul_done_q) begin
						op_a_q   <= d_q - prod;
						op_b_q   <= t_q;
						div_go_q <= 1'b1;
						state_q  <= E_TDIV;
					end
				end
				E_TDIV: begin
					if (div_done_q) begin
						t_q <= q_floor;
						n_q <= n_q + NW'(1);
						if (n_q != '0) begin
							j_q     <= AW'(1);
							hr_ra_q <= AW'(1);
							state_q <= E_HWAIT;
						end else begin
							state_q <= E_HWR;
						end
					end
				end
				E_HWAIT: begin
					state_q <= E_HCMP;
				end
				E_HCMP: begin
					if (hr_rdata == {s_q, t_q}) begin
						found_q  <= 1'b1;
						period_q <= j_q;
						per_q    <= 1'b1;
						st_q     <= qicf_pkg::STATUS_OK;
						k_q      <= '0;
						state_q  <= E_EMIT;
					end else if (NW'(j_q) + NW'(1) < n_q) begin
						j_q     <= j_q + AW'(1);
						hr_ra_q <= j_q + AW'(1);
						state_q <= E_HWAIT;
					end else begin
						state_q <= E_HWR;
					end
				end
				E_HWR: begin
					if (n_q < NW'(MAX_TERMS)) begin
						hr_we_q <= 1'b1;
						hr_wa_q <= n_q[AW-1:0];
						hr_wd_q <= {s_q, t_q};
					end
					if (n_q < NW'(MAX_TERMS) && t_q != '0) begin
						op_a_q   <= a_num;
						op_b_q   <= t_q;
						div_go_q <= 1'b1;
						state_q  <= E_ADIV;
					end else begin
						per_q   <= 1'b1;
						st_q    <= qicf_pkg::STATUS_LIMIT;
						k_q     <= '0;
						state_q <= E_EMIT;
					end
				end
				E_EMIT: begin
					tr_ra_q <= k_q[AW-1:0];
					rd_v_s1 <= 1'b1;
					zero_s1 <= 1'b0;
					ps_s1   <= found_q && (k_q[AW-1:0] == period_q);
					last_s1 <= (k_q + NW'(1) == n_q);
					per_s1  <= per_q;
					st_s1   <= st_q;
					k_q     <= k_q + NW'(1);
					if (k_q + NW'(1) == n_q) begin
						state_q <= E_IDLE;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s2  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			rd_v_s2  <= rd_v_s1;
			zero_s2  <= zero_s1;
			ps_s2    <= ps_s1;
			last_s2  <= last_s1;
			per_s2   <= per_s1;
			st_s2    <= st_s1;
			strobe_q <= rd_v_s2;
			term_q   <= zero_s2 ? '0 : tr_rdata;
			ps_q     <= ps_s2;
			last_q   <= last_s2;
			perio_q  <= per_s2;
			status_q <= st_s2;
		end
	end

	assign strobe          = strobe_q;
	assign term            = term_q;
	assign is_period_start = ps_q;
	assign is_last         = last_q;
	assign is_periodic     = perio_q;
	assign status          = status_q;

	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_go_q |-> !mul_busy_q) else $error("multiplier restarted while busy");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> !div_busy_q) else $error("divider restarted while busy");
	a_zero_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && status_q == qicf_pkg::STATUS_ZERO_DEN) |-> last_q)
		else $error("zero denominator word not marked last");
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_EMIT) |-> (k_q < n_q)) else $error("emit index past term count");

endmodule

// ----- rtl/quadratic_irrational_cf_expander.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_irrational_cf_expander
// Continued fraction expansion of (s_start + sqrt radicand) / t_start.
// ----------------------------------------------------------------------------
// front: one request at a time, busy until pushed, then a 2-word queue to the term engine
// square radicand: each term takes one pass of the radix-2 divider
// otherwise a setup pass, then per term a divide, two multiplies, a divide and a history
// search (divider, 4-bit-per-cycle multiplier, one history ram read per compare)
// words then stream one per cycle through the s1, s2 and output registers
// reset clears the state machines, counters and valid flags; term and history rams are not cleared
module quadratic_irrational_cf_expander #(
	parameter int MAX_TERMS = qicf_pkg::MAX_TERMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [15:0]                 s_start,
	input  logic [15:0]                 radicand,
	input  logic [15:0]                 t_start,
	output logic                        strobe,
	output logic [qicf_pkg::TERM_W-1:0] term,
	output logic                        is_period_start,
	output logic                        is_last,
	output logic                        is_periodic,
	output logic [1:0]                  status
);

	qicf_pkg::item_t push_item, pop_item;
	logic            push, full, pop, empty;

	qicf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.s_start   (s_start),
		.radicand  (radicand),
		.t_start   (t_start),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	qicf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	qicf_engine #(.MAX_TERMS(MAX_TERMS)) u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.empty           (empty),
		.pop_item        (pop_item),
		.pop             (pop),
		.strobe          (strobe),
		.term            (term),
		.is_period_start (is_period_start),
		.is_last         (is_last),
		.is_periodic     (is_periodic),
		.status          (status)
	);

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quadratic irrational continued fraction
// expander. Requests go in through the start/busy command port. A scoreboard
// class predicts every term word and compares it with the strobed output.
// ----------------------------------------------------------------------------
module tb;

	localparam int NTERMS   = qicf_pkg::MAX_TERMS_DEF;
	localparam int WD_LIMIT = 200000;

	typedef struct packed {
		logic [31:0] term;
		logic        ps;
		logic        last;
		logic        per;
		logic [1:0]  st;
	} cf_word_t;

	class cf_scoreboard;
		cf_word_t expected_words[$];
		int       fails;
		int       n_req;
		int       n_words;
		int       n_periodic;
		int       n_limit;

		function longint fdiv(longint n, longint d);
			longint q;
			if (d == 0)
				return 0;
			q = n / d;
			if ((n % d != 0) && ((n < 0) != (d < 0)))
				q--;
			return q;
		endfunction

		function longint isqrt(longint unsigned v);
			longint unsigned res;
			longint unsigned b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return longint'(res);
		endfunction

		function void push(longint a, bit ps, bit last, bit per, logic [1:0] st);
			cf_word_t w;
			w.term = a[31:0];
			w.ps   = ps;
			w.last = last;
			w.per  = per;
			w.st   = st;
			expected_words.push_back(w);
		endfunction

		function void note_request(logic [15:0] s0, logic [15:0] d0, logic [15:0] t0);
			longint s, d, t, root, p, q, a, r, at;
			longint hs[NTERMS];
			longint ht[NTERMS];
			longint terms[NTERMS];
			int     n, period;
			s = longint'($signed(s0));
			d = longint'(d0);
			t = longint'($signed(t0));
			n = 0;
			period = -1;
			n_req++;
			if (t == 0) begin
				push(0, 0, 1, 0, qicf_pkg::STATUS_ZERO_DEN);
				return;
			end
			root = isqrt(d);
			if (root * root == d) begin
				p = s + root;
				q = t;
				if (q < 0) begin
					p = -p;
					q = -q;
				end
				while (n < NTERMS) begin
					a = fdiv(p, q);
					r = p - a * q;
					terms[n] = a;
					n++;
					if (r == 0)
						break;
					p = q;
					q = r;
				end
				for (int k = 0; k < n; k++)
					push(terms[k], 0, k == n - 1, 0, qicf_pkg::STATUS_OK);
				return;
			end
			if ((d - s * s) % t != 0) begin
				at = t < 0 ? -t : t;
				s *= at;
				d *= t * t;
				t *= at;
			end
			root = isqrt(d);
			hs[0] = s;
			ht[0] = t;
			while (n < NTERMS && period < 0) begin
				if (t == 0)
					break;
				a = (t > 0) ? fdiv(s + root, t) : fdiv(s + root + 1, t);
				terms[n] = a;
				s = a * t - s;
				t = fdiv(d - s * s, t);
				n++;
				for (int j = 1; j < n; j++) begin
					if (hs[j] == s && ht[j] == t) begin
						period = j;
						break;
					end
				end
				if (period < 0 && n < NTERMS) begin
					hs[n] = s;
					ht[n] = t;
				end
			end
			n_periodic++;
			if (period < 0)
				n_limit++;
			for (int k = 0; k < n; k++)
				push(terms[k], k == period, k == n - 1, 1,
					period < 0 ? qicf_pkg::STATUS_LIMIT : qicf_pkg::STATUS_OK);
		endfunction

		function void check_word(cf_word_t got);
			cf_word_t exp_w;
			n_words++;
			if (expected_words.size() == 0) begin
				$error("unexpected word term=%0d", $signed(got.term));
				fails++;
				return;
			end
			exp_w = expected_words.pop_front();
			if (got.term !== exp_w.term) begin
				$error("term: expected %0d actual %0d", $signed(exp_w.term),
					$signed(got.term));
				fails++;
			end
			if (got.ps !== exp_w.ps) begin
				$error("is_period_start: expected %0b actual %0b", exp_w.ps, got.ps);
				fails++;
			end
			if (got.last !== exp_w.last) begin
				$error("is_last: expected %0b actual %0b", exp_w.last, got.last);
				fails++;
			end
			if (got.per !== exp_w.per) begin
				$error("is_periodic: expected %0b actual %0b", exp_w.per, got.per);
				fails++;
			end
			if (got.st !== exp_w.st) begin
				$error("status: expected %0d actual %0d", exp_w.st, got.st);
				fails++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] s_start;
	logic [15:0] radicand;
	logic [15:0] t_start;
	logic        strobe;
	logic [31:0] term;
	logic        is_period_start;
	logic        is_last;
	logic        is_periodic;
	logic [1:0]  status;

	cf_scoreboard sb = new();
	int           idle_cycles;

	quadratic_irrational_cf_expander i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.s_start         (s_start),
		.radicand        (radicand),
		.t_start         (t_start),
		.strobe          (strobe),
		.term            (term),
		.is_period_start (is_period_start),
		.is_last         (is_last),
		.is_periodic     (is_periodic),
		.status          (status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_request(s_start, radicand, t_start);
			if (strobe)
				sb.check_word({term, is_period_start, is_last, is_periodic, status});
			if ((start && !busy) || strobe)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WD_LIMIT) begin
				$display("FAIL quadratic_irrational_cf_expander");
				$finish;
			end
		end
	end

	task automatic send_request(logic [15:0] s0, logic [15:0] d0, logic [15:0] t0,
			int gap);
		start    <= 1'b1;
		s_start  <= s0;
		radicand <= d0;
		t_start  <= t0;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random(int gap);
		logic [15:0] s0, d0, t0;
		if ($urandom_range(9) == 0) begin
			s0 = $urandom;
			d0 = $urandom;
			t0 = $urandom;
		end else begin
			s0 = 16'($signed($urandom_range(100)) - 50);
			d0 = 16'($urandom_range(400));
			t0 = 16'($signed($urandom_range(100)) - 50);
			if (t0 == 0 && $urandom_range(3) != 0)
				t0 = 16'd1;
		end
		send_request(s0, d0, t0, gap);
	endtask

	initial begin
		start       = 1'b0;
		s_start     = '0;
		radicand    = '0;
		t_start     = '0;
		idle_cycles = 0;
		arst_n      = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero denominator, square radicands, signs and extremes
		send_request(16'sd3, 16'd2, 16'sd0, 0);
		send_request(16'sd0, 16'd0, 16'sd1, 3);
		send_request(16'sd1, 16'd1, 16'sd2, 0);
		send_request(-16'sd5, 16'd49, 16'sd3, 1);
		send_request(16'sd7, 16'd64, -16'sd3, 0);
		send_request(16'sd0, 16'd2, 16'sd1, 2);
		send_request(16'sd0, 16'd7, -16'sd1, 0);
		send_request(16'sd1, 16'd5, 16'sd2, 0);
		send_request(-16'sd3, 16'd13, -16'sd4, 5);
		send_request(16'h8000, 16'd2, 16'sd1, 0);
		send_request(16'h7fff, 16'd3, 16'h7fff, 0);
		send_request(16'sd0, 16'hffff, 16'sd1, 4);
		send_request(16'h8000, 16'hffff, 16'h8000, 0);
		send_request(16'h7fff, 16'hfffe, -16'sd7, 0);
		send_request(16'sd0, 16'hff01, 16'h7fff, 0);
		send_request(16'sd0, 16'd65521, 16'sd1, 0);
		send_request(16'sd123, 16'd61141, 16'sd777, 0);
		send_request(16'h5555, 16'haaaa, 16'h2aaa, 1);
		drain();

		for (int i = 0; i < 140; i++) begin
			if (i == 70)
				drain();
			send_random($urandom_range(3) == 0 ? 0 : $urandom_range(15));
		end
		drain();
		repeat (50) @(posedge clk);

		$display("covered %0d requests, %0d words, %0d periodic, %0d at term limit",
			sb.n_req, sb.n_words, sb.n_periodic, sb.n_limit);
		if (sb.fails == 0 && sb.expected_words.size() == 0)
			$display("PASS quadratic_irrational_cf_expander");
		else
			$display("FAIL quadratic_irrational_cf_expander");
		$finish;
	end

endmodule
